// ===== rtl/core/ncsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ncsf_pkg
// shared constants and payload types of the neighbour-count sketch filter
// ----------------------------------------------------------------------------
package ncsf_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CLEAR  = 2'd2;

	localparam logic [7:0] GRAY_MARK  = 8'd254;
	localparam logic [7:0] GRAY_WHITE = 8'd255;
	localparam logic [7:0] GRAY_S1    = 8'd150;
	localparam logic [7:0] GRAY_S2    = 8'd100;
	localparam logic [7:0] GRAY_S3    = 8'd50;
	localparam logic [9:0] SUM_LIMIT  = 10'd762;

	typedef struct packed {
		logic       opcode;
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic       last_pixel;
	} in_item_t;

	typedef struct packed {
		logic [7:0] gray;
		logic       last_of_frame;
	} out_item_t;

endpackage

// ===== rtl/core/ncsf_in_if.sv =====
// ----------------------------------------------------------------------------
// ncsf_in_if
// valid/ready channel carrying input beats
// ----------------------------------------------------------------------------
interface ncsf_in_if;
	import ncsf_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ncsf_out_if.sv =====
// ----------------------------------------------------------------------------
// ncsf_out_if
// valid/ready channel carrying result beats
// ----------------------------------------------------------------------------
interface ncsf_out_if;
	import ncsf_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/neighbour_count_sketch_filter.sv =====
// ----------------------------------------------------------------------------
// neighbour_count_sketch_filter
// frame store with in-place neighbour-count transform, clear and sketch passes
// ----------------------------------------------------------------------------
// A write beat passes through ST_WRITE, and a read beat through ST_RD_ADDR
// and ST_RD_DATA, where it waits on output back-pressure. The write beat
// flagged last_pixel runs (2 + clear_passes) in-place passes over the frame,
// columns outer and rows inner; every visited pixel takes these steps on the
// single frame memory read port: centre address, centre read, eight
// neighbour reads, a final compare and write, and a step to the next pixel.
// A non-zero pixel that a clear or sketch pass skips takes only the centre
// address, the centre read and the step. All passes are bound by that one
// port. The neighbour reads are compared one by one against the centre by a
// single shared comparator that feeds a 4-bit counter. During processing
// in.ready stays low. The frame memory has no reset: reading out a frame
// containing pixels never written since reset returns undefined data.
module neighbour_count_sketch_filter #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	ncsf_in_if.sink             in,
	ncsf_out_if.source          out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import ncsf_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int PW    = AW + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WRITE, ST_RD_ADDR, ST_RD_DATA, ST_OUT,
		ST_PIX_START, ST_CENTER, ST_NBR, ST_DECIDE, ST_NEXT
	} state_t;

	// configuration registers
	logic [7:0] width_q, height_q;
	logic [3:0] clear_q;
	logic       wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd128;
			height_q <= 8'd128;
			clear_q  <= 4'd1;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[7:0];
				REG_HEIGHT: height_q <= pwdata[7:0];
				REG_CLEAR:  clear_q  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = {24'd0, width_q};
			REG_HEIGHT: prdata = {24'd0, height_q};
			REG_CLEAR:  prdata = {28'd0, clear_q};
			default:    prdata = 32'd0;
		endcase
	end

	// effective frame size, clamped to 1..max
	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	logic [PW-1:0] size_eff;
	always_comb begin
		if (width_q == 8'd0) w_eff = XW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
		else w_eff = XW'(width_q);
		if (height_q == 8'd0) h_eff = YW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
		else h_eff = YW'(height_q);
	end
	// w*h registered each cycle; user keeps config static while busy, unchecked
	logic [PW-1:0] size_q;
	always_ff @(posedge clk) size_q <= PW'(w_eff * h_eff);
	assign size_eff = size_q;

	// frame memory, one port shared by load, passes and read-out
	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata, mem_rdata;
	logic          mem_we;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		mem_rdata <= mem[mem_addr];
	end

	state_t        state_q;
	logic [PW-1:0] load_pos_q, read_pos_q;
	logic          ready_q;
	in_item_t      item_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [1:0]    mode_q;       // 0 transform, 1 clear, 2 sketch
	logic [3:0]    pass_q;       // clear passes done
	logic [3:0]    nbr_q;        // neighbour index 0..7
	logic [3:0]    cnt_q;        // equal neighbours
	logic [7:0]    ctr_q;        // centre value
	logic          chk_q;        // previous cycle issued an in-frame read
	logic [PW-1:0] rowbase_q;    // y*w
	logic          ovalid_q;
	out_item_t     odata_q;

	assign in.ready  = (state_q == ST_IDLE);
	assign out.valid = ovalid_q;
	assign out.data  = odata_q;

	// neighbour offset for index n (skipping the centre)
	logic signed [1:0] dx, dy;
	always_comb begin
		unique case (nbr_q)
			4'd0: begin dx = -2'sd1; dy = -2'sd1; end
			4'd1: begin dx =  2'sd0; dy = -2'sd1; end
			4'd2: begin dx =  2'sd1; dy = -2'sd1; end
			4'd3: begin dx = -2'sd1; dy =  2'sd0; end
			4'd4: begin dx =  2'sd1; dy =  2'sd0; end
			4'd5: begin dx = -2'sd1; dy =  2'sd1; end
			4'd6: begin dx =  2'sd0; dy =  2'sd1; end
			default: begin dx = 2'sd1; dy = 2'sd1; end
		endcase
	end

	logic signed [XW+1:0] nx;
	logic signed [YW+1:0] ny;
	logic                 n_in;
	logic [PW-1:0]        n_addr, c_addr;
	assign nx   = $signed({2'b00, x_q}) + (XW+2)'(dx);
	assign ny   = $signed({2'b00, y_q}) + (YW+2)'(dy);
	assign n_in = (nx >= 0) && (ny >= 0) && (nx < $signed({2'b00, w_eff}))
		&& (ny < $signed({2'b00, h_eff}));
	// row base steps by +-w so no multiplier is needed per access
	always_comb begin
		logic [PW-1:0] rb;
		rb = rowbase_q;
		if (dy < 0) rb = rowbase_q - PW'(w_eff);
		else if (dy > 0) rb = rowbase_q + PW'(w_eff);
		n_addr = rb + PW'(unsigned'(nx[XW-1:0]));
	end
	assign c_addr = rowbase_q + PW'(x_q);

	logic [9:0] ch_sum;
	assign ch_sum = 10'(item_q.chan0) + 10'(item_q.chan1) + 10'(item_q.chan2);

	logic hit;
	assign hit = chk_q && (mem_rdata == ctr_q);

	// memory port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = AW'(read_pos_q);
		mem_wdata = (ch_sum >= SUM_LIMIT) ? GRAY_MARK : 8'd0;
		unique case (state_q)
			ST_WRITE: begin
				mem_addr = AW'(load_pos_q);
				mem_we   = (load_pos_q < size_eff);
			end
			ST_PIX_START: mem_addr = AW'(c_addr);
			ST_NBR:       mem_addr = AW'(n_addr);
			ST_DECIDE: begin
				mem_addr = AW'(c_addr);
				if (mode_q == 2'd0) begin
					mem_we    = 1'b1;
					mem_wdata = (cnt_q + 4'(hit) >= 4'd2) ? GRAY_WHITE : 8'd0;
				end else if (ctr_q == 8'd0) begin
					mem_we = (mode_q == 2'd2) || (cnt_q + 4'(hit) <= 4'd3);
					if (mode_q == 2'd1) mem_wdata = GRAY_WHITE;
					else begin
						unique case (cnt_q + 4'(hit))
							4'd0, 4'd1: mem_wdata = GRAY_S1;
							4'd2:       mem_wdata = GRAY_S2;
							4'd3:       mem_wdata = GRAY_S3;
							default:    mem_wdata = 8'd0;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_pos_q <= '0;
			read_pos_q <= '0;
			ready_q    <= 1'b0;
			ovalid_q   <= 1'b0;
			odata_q    <= '0;
			item_q     <= '0;
			x_q        <= '0;
			y_q        <= '0;
			mode_q     <= 2'd0;
			pass_q     <= 4'd0;
			nbr_q      <= 4'd0;
			cnt_q      <= 4'd0;
			ctr_q      <= 8'd0;
			chk_q      <= 1'b0;
			rowbase_q  <= '0;
		end else begin
			// the read-out state loads the next beat itself
			if (out.valid && out.ready && state_q != ST_RD_DATA) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in.valid) begin
						item_q <= in.data;
						if (in.data.opcode == OP_WRITE) begin
							state_q <= ST_WRITE;
						end else if (!ready_q || read_pos_q >= size_eff) begin
							ready_q <= 1'b0;
						end else begin
							state_q <= ST_RD_ADDR;
						end
					end
				end
				ST_WRITE: begin
					ready_q    <= 1'b0;
					read_pos_q <= '0;
					load_pos_q <= (load_pos_q < size_eff) ? load_pos_q + 1'b1 : size_eff;
					if (item_q.last_pixel) begin
						x_q <= '0; y_q <= '0; rowbase_q <= '0;
						mode_q <= 2'd0; pass_q <= 4'd0;
						state_q <= ST_PIX_START;
					end else state_q <= ST_IDLE;
				end
				ST_RD_ADDR: state_q <= ST_RD_DATA;
				ST_RD_DATA: begin
					if (!ovalid_q || out.ready) begin
						ovalid_q <= 1'b1;
						odata_q.gray <= mem_rdata;
						odata_q.last_of_frame <= (read_pos_q + 1'b1 == size_eff);
						if (read_pos_q + 1'b1 >= size_eff) begin
							ready_q <= 1'b0; read_pos_q <= '0;
						end else read_pos_q <= read_pos_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_PIX_START: state_q <= ST_CENTER;
				ST_CENTER: begin
					ctr_q <= mem_rdata;
					nbr_q <= 4'd0; cnt_q <= 4'd0; chk_q <= 1'b0;
					if (mode_q != 2'd0 && mem_rdata != 8'd0) state_q <= ST_NEXT;
					else state_q <= ST_NBR;
				end
				ST_NBR: begin
					cnt_q <= cnt_q + 4'(hit);
					chk_q <= n_in;
					if (nbr_q == 4'd7) state_q <= ST_DECIDE;
					else nbr_q <= nbr_q + 1'b1;
				end
				ST_DECIDE: state_q <= ST_NEXT;
				ST_NEXT: begin
					state_q <= ST_PIX_START;
					if (PW'(y_q) + 1'b1 < PW'(h_eff)) begin
						y_q <= y_q + 1'b1;
						rowbase_q <= rowbase_q + PW'(w_eff);
					end else begin
						y_q <= '0; rowbase_q <= '0;
						if (PW'(x_q) + 1'b1 < PW'(w_eff)) x_q <= x_q + 1'b1;
						else begin
							x_q <= '0;
							priority if (mode_q == 2'd2) begin
								state_q <= ST_IDLE;
								ready_q <= 1'b1;
								load_pos_q <= '0; read_pos_q <= '0;
							end else if (mode_q == 2'd0) begin
								mode_q <= (clear_q == 4'd0) ? 2'd2 : 2'd1;
							end else if (pass_q + 1'b1 >= clear_q) begin
								mode_q <= 2'd2;
							end else pass_q <= pass_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
